>>> src/lfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and fixed field layout of the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    // Fixed widths of the stream fields
    localparam int IN_TIME_W   = 32;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 1;
    localparam int OUT_IDX_W   = 6;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 2;

    // Bit positions inside m_tuser
    localparam int TUSER_NO_SLOT    = 0;
    localparam int TUSER_TARGET_HIT = 1;

    // Request sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_GRANT = 3'b100
    } state_t;

endpackage

>>> src/lowest_free_slot_allocator_core.sv
`timescale 1ns / 1ps
// A taken request walks the open slots in ST_SCAN, then ST_GRANT registers its
//   grant; with no slot open yet it goes straight to ST_GRANT; a hit ends the scan early.
// One request at a time: the input stays closed until ST_GRANT hands the grant
//   to the output register; the scan reads the release-time RAM one entry per cycle.
// Reset: rst_n clears the open-slot count, the sequencer and the output valid.
//   The RAM is not cleared; only entries below the open count are ever read.
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_core
// Grants the lowest open slot whose release time has passed, else opens a new
// slot and stores the departure time as its next release time; if none, flags no_slot.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_core #(
    parameter int SLOT_COUNT = 64,
    parameter int TIME_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [31:0] arrival_time, [63:32] departure_time
    input  logic [lfsa_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] marks_target
    input  logic [lfsa_pkg::S_TUSER_W-1:0]  s_tuser,
    // Grant stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [5:0] slot_index, [7:6] zero
    output logic [lfsa_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] no_slot, [1] target_hit
    output logic [lfsa_pkg::M_TUSER_W-1:0]  m_tuser
);

    // Times above the port width cannot occur, so store at most that many bits
    localparam int STORE_W = (TIME_WIDTH < lfsa_pkg::IN_TIME_W) ?
                             TIME_WIDTH : lfsa_pkg::IN_TIME_W;
    localparam int IDX_W   = $clog2(SLOT_COUNT);
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);

    lfsa_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     opened_reg, opened_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [STORE_W-1:0]   arrive_reg, arrive_next;
    logic [STORE_W-1:0]   depart_reg, depart_next;
    logic                 target_reg, target_next;

    logic                           m_valid_reg, m_valid_next;
    logic [lfsa_pkg::OUT_IDX_W-1:0] m_slot_reg, m_slot_next;
    logic                           m_none_reg, m_none_next;
    logic                           m_hit_reg, m_hit_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic                 ram_re;
    logic [STORE_W-1:0]   ram_rdata;

    logic                 in_fire;
    logic                 out_free;
    logic                 scan_hit;
    logic                 more_to_read;
    logic                 new_ok;

    // Release time per slot
    lfsa_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SLOT_COUNT)
    ) u_release_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (depart_reg),
        .re    (ram_re),
        .raddr (issue_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready     = (state_reg == lfsa_pkg::ST_IDLE);
    assign in_fire      = s_tvalid && s_tready;
    assign out_free     = !m_valid_reg || m_tready;
    // The entry read last cycle is free for this request
    assign scan_hit     = chk_valid_reg && (ram_rdata <= arrive_reg);
    assign more_to_read = (issue_reg < opened_reg);
    assign new_ok       = (opened_reg < CNT_W'(SLOT_COUNT));
    assign ram_re       = (state_reg == lfsa_pkg::ST_SCAN) && !scan_hit && more_to_read;
    assign ram_we       = (state_reg == lfsa_pkg::ST_GRANT) && out_free &&
                          (found_reg || new_ok);
    // Reuse the found slot, else open the next fresh one
    assign ram_waddr    = found_reg ? pick_reg : opened_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        opened_next    = opened_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        arrive_next    = arrive_reg;
        depart_next    = depart_reg;
        target_next    = target_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_slot_next    = m_slot_reg;
        m_none_next    = m_none_reg;
        m_hit_next     = m_hit_reg;

        case (state_reg)
            lfsa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    // Latch the request and start the scan at slot zero
                    arrive_next = s_tdata[STORE_W-1:0];
                    depart_next = s_tdata[lfsa_pkg::IN_TIME_W +: STORE_W];
                    target_next = s_tuser[0];
                    found_next  = 1'b0;
                    issue_next  = '0;
                    state_next  = (opened_reg == '0) ? lfsa_pkg::ST_GRANT
                                                     : lfsa_pkg::ST_SCAN;
                end
            end

            lfsa_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    found_next = 1'b1;
                    pick_next  = chk_idx_reg;
                    state_next = lfsa_pkg::ST_GRANT;
                end
                else if (more_to_read)
                begin
                    // Issue the next read, check it next cycle
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[IDX_W-1:0];
                    issue_next     = issue_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = lfsa_pkg::ST_GRANT;
                end
            end

            lfsa_pkg::ST_GRANT:
            begin
                // Hold until the output register can take the grant
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        m_slot_next = lfsa_pkg::OUT_IDX_W'(pick_reg);
                        m_none_next = 1'b0;
                        m_hit_next  = target_reg;
                    end
                    else if (new_ok)
                    begin
                        m_slot_next = lfsa_pkg::OUT_IDX_W'(opened_reg);
                        m_none_next = 1'b0;
                        m_hit_next  = target_reg;
                        opened_next = opened_reg + CNT_W'(1);
                    end
                    else
                    begin
                        // Every slot busy: grant nothing, open count unchanged
                        m_slot_next = '0;
                        m_none_next = 1'b1;
                        m_hit_next  = 1'b0;
                    end
                    state_next = lfsa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lfsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfsa_pkg::ST_IDLE;
            opened_reg    <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload and scan bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        issue_reg   <= issue_next;
        chk_idx_reg <= chk_idx_next;
        found_reg   <= found_next;
        pick_reg    <= pick_next;
        arrive_reg  <= arrive_next;
        depart_reg  <= depart_next;
        target_reg  <= target_next;
        m_slot_reg  <= m_slot_next;
        m_none_reg  <= m_none_next;
        m_hit_reg   <= m_hit_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lfsa_pkg::M_TDATA_W'(m_slot_reg);
    assign m_tuser  = {m_hit_reg, m_none_reg};

endmodule

>>> src/lfsa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lfsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lfsa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lfsa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lfsa_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready
);

    // A stalled grant stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("grant dropped while stalled");

    // A stalled grant keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("grant payload changed while stalled");

    // One request in flight: a taken request closes the input
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in flight");

    // A refused request carries no slot and no target echo
    a_no_slot_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[lfsa_pkg::TUSER_NO_SLOT] |->
            (m_tdata == '0) && !m_tuser[lfsa_pkg::TUSER_TARGET_HIT])
        else $error("refused request shows a slot or target echo");

endmodule

bind lowest_free_slot_allocator_core lfsa_checker u_lfsa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
